// ===== hdl/rmrc_pkg.sv =====
package rmrc_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RED_MARGIN   = 2'd2;

	localparam logic [7:0] WIDTH_RESET  = 8'd160;
	localparam logic [7:0] HEIGHT_RESET = 8'd120;
	localparam logic [5:0] MARGIN_RESET = 6'd3;

	localparam logic [7:0] MASK_RED   = 8'h00;
	localparam logic [7:0] MASK_OTHER = 8'hff;

	localparam logic [7:0] MIN_HEIGHT = 8'd5;
	localparam logic [6:0] COUNT_MAX  = 7'd127;
	// a closed run counts when its length is over this
	localparam logic [8:0] RUN_MIN    = 9'd2;

	typedef logic [7:0] coord_t;

endpackage

// ===== hdl/rmrc_pixel_class.sv =====
module rmrc_pixel_class (
	input  logic [15:0] pixel_word,
	input  logic [5:0]  red_margin,
	output logic        is_red
);
	import rmrc_pkg::*;

	logic [4:0] red_f;
	logic [5:0] green_f;
	logic [4:0] blue_f;
	logic [6:0] green_lim;
	logic [6:0] blue_lim;

	// bytes are swapped before the RGB565 split
	assign red_f   = pixel_word[7:3];
	assign green_f = {pixel_word[2:0], pixel_word[15:13]};
	assign blue_f  = pixel_word[12:8];

	assign green_lim = {1'b0, green_f} + {1'b0, red_margin};
	assign blue_lim  = {2'b00, blue_f} + {1'b0, red_margin};

	assign is_red = ({2'b00, red_f} > green_lim) && ({2'b00, red_f} > blue_lim);

endmodule

// ===== hdl/red_mask_and_row_run_count.sv =====
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------------
// in      | input     | in_valid / in_stall  | pixel_word
// out     | output    | out_valid / out_stall| mask_value, frame_end, run_count,
//         |           |                      | result_status
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per clock sustained while out_stall stays low; each item passes the
// input register, then the result register. Classification and the run update
// are one compare-and-add level between the two registers.
// arst_n clears counters, run state, valid flags and loads register defaults.
// The result register frees up whenever out_stall is low, so a new item enters
// while an earlier result still waits; in_stall rises only with both stages full
// and the output stalled. cfg_ready is always high.
module red_mask_and_row_run_count (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] pixel_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  mask_value,
	output logic        frame_end,
	output logic [6:0]  run_count,
	output logic        result_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import rmrc_pkg::*;

	// configuration
	coord_t     width_q;
	coord_t     height_q;
	logic [5:0] margin_q;

	// input register
	logic        vld_s1;
	logic [15:0] pix_s1;

	// result register
	logic        vld_s2;
	logic [7:0]  mask_s2;
	logic        fend_s2;
	logic [6:0]  cnt_s2;
	logic        stat_s2;

	// frame and run state
	coord_t     col_q;
	coord_t     row_q;
	logic       prev_red_q;
	logic       run_open_q;
	coord_t     run_start_q;
	logic [6:0] runs_q;

	logic       out_free;
	logic       advance;
	logic       is_red;
	logic       row_end;
	logic       frame_done;
	logic       on_mid;
	coord_t     left_col;
	logic       run_begin;
	logic       run_close;
	logic       run_counts;
	logic [6:0] runs_next;

	assign cfg_ready = 1'b1;

	// result register can take a new item when empty or being drained
	assign out_free = !vld_s2 || !out_stall;
	assign advance  = vld_s1 && out_free;
	assign in_stall = vld_s1 && !out_free;

	rmrc_pixel_class u_class (
		.pixel_word (pix_s1),
		.red_margin (margin_q),
		.is_red     (is_red)
	);

	assign row_end    = (col_q == width_q - 8'd1);
	assign frame_done = row_end && (row_q == height_q - 8'd1);
	assign on_mid     = (row_q == {1'b0, height_q[7:1]}) && (col_q != 8'd0);
	assign left_col   = col_q - 8'd1;

	// a run opens on two reds in a row and closes on two non-reds in a row
	assign run_begin  = on_mid && !run_open_q && prev_red_q && is_red;
	assign run_close  = on_mid && run_open_q && !prev_red_q && !is_red;
	assign run_counts = run_close &&
		({1'b0, left_col} > {1'b0, run_start_q} + RUN_MIN) && (runs_q != COUNT_MAX);
	assign runs_next  = run_counts ? runs_q + 7'd1 : runs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			margin_q <= MARGIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				REG_RED_MARGIN:   margin_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pix_s1 <= pixel_word;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_s2 <= is_red ? MASK_RED : MASK_OTHER;
			fend_s2 <= frame_done;
			cnt_s2  <= (frame_done && height_q >= MIN_HEIGHT) ? runs_next : 7'd0;
			stat_s2 <= frame_done && (height_q < MIN_HEIGHT);
		end
	end

	// raster position and run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			prev_red_q  <= 1'b0;
			run_open_q  <= 1'b0;
			run_start_q <= '0;
			runs_q      <= '0;
		end else if (advance) begin
			if (row_end) begin
				col_q      <= '0;
				prev_red_q <= 1'b0;
				run_open_q <= 1'b0;
				if (frame_done) begin
					row_q       <= '0;
					runs_q      <= '0;
					run_start_q <= '0;
				end else begin
					row_q  <= row_q + 8'd1;
					runs_q <= runs_next;
					if (run_begin) begin
						run_start_q <= left_col;
					end
				end
			end else begin
				col_q      <= col_q + 8'd1;
				prev_red_q <= is_red;
				runs_q     <= runs_next;
				if (run_begin) begin
					run_open_q  <= 1'b1;
					run_start_q <= left_col;
				end else if (run_close) begin
					run_open_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid     = vld_s2;
	assign mask_value    = mask_s2;
	assign frame_end     = fend_s2;
	assign run_count     = cnt_s2;
	assign result_status = stat_s2;

endmodule

// ===== hdl/rmrc_checker.sv =====
module rmrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [15:0] pixel_word,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  mask_value,
	input logic        frame_end,
	input logic [6:0]  run_count,
	input logic        result_status,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [7:0]  cfg_data
);
	import rmrc_pkg::*;

	logic unused_ok;
	assign unused_ok = in_valid ^ in_stall ^ (^pixel_word) ^ cfg_valid ^ cfg_ready ^
		(^cfg_index) ^ (^cfg_data);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	// a stalled result keeps its mask
	a_mask_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(mask_value))
		else $error("mask changed under stall");

	a_mask_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mask_value == MASK_RED || mask_value == MASK_OTHER))
		else $error("mask not a class code");

	// count and status only on the frame's last pixel
	a_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> run_count == 7'd0 && !result_status)
		else $error("count or status outside frame end");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_status |-> run_count == 7'd0)
		else $error("count reported with invalid status");

endmodule

bind red_mask_and_row_run_count rmrc_checker u_rmrc_checker (.*);
